### design/lzt_pkg.sv
// Shared types and constants of the trie phrase decoder.
`default_nettype none

package lzt_pkg;

   // Code and node geometry.
   localparam int CODE_W  = 13;
   localparam int ACC_W   = 32;
   localparam int WORD_W  = 16;
   localparam int SLOT_W  = 14;
   localparam int TOTAL_W = 31;

   localparam logic [CODE_W-1:0] NIL        = 13'h1fff;
   localparam logic [SLOT_W-1:0] NODES      = 14'h2000;
   localparam logic [SLOT_W-1:0] LAST_SLOT  = 14'h1ffe;
   localparam logic [SLOT_W-1:0] FIRST_SLOT = 14'h0100;

   // Extension depth and result packing.
   localparam int MAX_EXTEND       = 4;
   localparam int BYTES_PER_RESULT = 4;
   localparam int OUT_W            = 8 * BYTES_PER_RESULT;
   localparam int CNT_W            = 3;
   localparam int STATUS_W         = 3;

   // Status codes reported with the last result of a request.
   localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_SIZE   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LONG   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NONODE = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SHORT  = 3'd4;

   // Datapath operations issued by the controller.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLEAR,
      OP_ACCEPT,
      OP_SETTLE,
      OP_LOAD,
      OP_TAKE_CODE,
      OP_FAIL_LONG,
      OP_WALK_RD,
      OP_WALK_WR,
      OP_EMIT_BEGIN,
      OP_EMIT_BYTE,
      OP_CODE_DONE,
      OP_EXT_BEGIN,
      OP_LATCH_BYTE,
      OP_HEAD,
      OP_NO_MATCH,
      OP_SRCH_RD,
      OP_MATCH,
      OP_SRCH_NEXT,
      OP_ALLOC_FREE,
      OP_SWEEP_BEGIN,
      OP_SWP_RD,
      OP_SWP_TAKE,
      OP_SWP_NEXT,
      OP_FAIL_NODE,
      OP_UNL_RD,
      OP_UNLINK,
      OP_LINK_NEW,
      OP_LINK_RD,
      OP_LINK_HEAD,
      OP_FINISH
   } op_type;

   // Conditions reported by the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic eos;
      logic stopped;
      logic size_reached;
      logic code_ready;
      logic node_nil;
      logic len_over;
      logic emit_more;
      logic emit_ok;
      logic pack_full;
      logic out_free;
      logic has_last;
      logic ext_more;
      logic must_alloc;
      logic m_nil;
      logic sym_match;
      logic guard_max;
      logic free_avail;
      logic swp_hit;
      logic swp_exhaust;
   } dp_status_type;

endpackage

`default_nettype wire

### design/lzt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

### design/lzt_ctrl.sv
// Controller state machine that sequences the decoder datapath.
`default_nettype none

module lzt_ctrl import lzt_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire dp_status_type flags,
   output op_type             op
);

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_START,
      S_LOOP,
      S_WALK,
      S_WALK_WR,
      S_EMIT_WAIT,
      S_EMIT,
      S_EXT_WAIT,
      S_EXT_BYTE,
      S_FIND_HEAD,
      S_SRCH,
      S_SRCH_CMP,
      S_ALLOC,
      S_SWP_WAIT,
      S_SWP_CMP,
      S_UNL_RD,
      S_UNL_WR,
      S_LINK1,
      S_LINK2,
      S_LINK3,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == S_IDLE);

   // Next state and datapath operation.
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_CLEAR: begin
            op = OP_CLEAR;
            if (flags.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op       = OP_ACCEPT;
               state_in = S_START;
            end
         end
         S_START: begin
            if (flags.eos || flags.stopped || flags.size_reached) begin
               op       = OP_SETTLE;
               state_in = S_FINISH;
            end else begin
               op       = OP_LOAD;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (flags.code_ready && !flags.stopped && !flags.size_reached) begin
               op       = OP_TAKE_CODE;
               state_in = S_WALK;
            end else begin
               op       = OP_SETTLE;
               state_in = S_FINISH;
            end
         end
         S_WALK: begin
            if (flags.node_nil) begin
               op       = OP_EMIT_BEGIN;
               state_in = S_EMIT_WAIT;
            end else if (flags.len_over) begin
               op       = OP_FAIL_LONG;
               state_in = S_LOOP;
            end else begin
               op       = OP_WALK_RD;
               state_in = S_WALK_WR;
            end
         end
         S_WALK_WR: begin
            op       = OP_WALK_WR;
            state_in = S_WALK;
         end
         S_EMIT_WAIT: begin
            if (flags.emit_more) begin
               state_in = S_EMIT;
            end else if (flags.has_last) begin
               op       = OP_EXT_BEGIN;
               state_in = S_EXT_WAIT;
            end else begin
               op       = OP_CODE_DONE;
               state_in = S_LOOP;
            end
         end
         S_EMIT: begin
            if (!(flags.emit_ok && flags.pack_full && !flags.out_free)) begin
               op       = OP_EMIT_BYTE;
               state_in = S_EMIT_WAIT;
            end
         end
         S_EXT_WAIT: begin
            if (flags.ext_more) begin
               state_in = S_EXT_BYTE;
            end else begin
               op       = OP_CODE_DONE;
               state_in = S_LOOP;
            end
         end
         S_EXT_BYTE: begin
            op       = OP_LATCH_BYTE;
            state_in = flags.must_alloc ? S_ALLOC : S_FIND_HEAD;
         end
         S_FIND_HEAD: begin
            op       = OP_HEAD;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            if (flags.m_nil) begin
               op       = OP_NO_MATCH;
               state_in = S_ALLOC;
            end else begin
               op       = OP_SRCH_RD;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            if (flags.sym_match) begin
               op       = OP_MATCH;
               state_in = S_EXT_WAIT;
            end else if (flags.guard_max) begin
               op       = OP_NO_MATCH;
               state_in = S_ALLOC;
            end else begin
               op       = OP_SRCH_NEXT;
               state_in = S_SRCH;
            end
         end
         S_ALLOC: begin
            if (flags.free_avail) begin
               op       = OP_ALLOC_FREE;
               state_in = S_LINK1;
            end else begin
               op       = OP_SWEEP_BEGIN;
               state_in = S_SWP_WAIT;
            end
         end
         S_SWP_WAIT: begin
            op       = OP_SWP_RD;
            state_in = S_SWP_CMP;
         end
         S_SWP_CMP: begin
            if (flags.swp_hit) begin
               op       = OP_SWP_TAKE;
               state_in = S_UNL_RD;
            end else if (flags.swp_exhaust) begin
               op       = OP_FAIL_NODE;
               state_in = S_LOOP;
            end else begin
               op       = OP_SWP_NEXT;
               state_in = S_SWP_WAIT;
            end
         end
         S_UNL_RD: begin
            op       = OP_UNL_RD;
            state_in = S_UNL_WR;
         end
         S_UNL_WR: begin
            op       = OP_UNLINK;
            state_in = S_LINK1;
         end
         S_LINK1: begin
            op       = OP_LINK_NEW;
            state_in = S_LINK2;
         end
         S_LINK2: begin
            op       = OP_LINK_RD;
            state_in = S_LINK3;
         end
         S_LINK3: begin
            op       = OP_LINK_HEAD;
            state_in = S_EXT_WAIT;
         end
         S_FINISH: begin
            if (flags.out_free) begin
               op       = OP_FINISH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/lzt_dpath.sv
// Decoder datapath: bit accumulator, trie memories, phrase buffer and result packer.
`default_nettype none

module lzt_dpath import lzt_pkg::*; #(
   parameter int MAX_PHRASE = 100,
   localparam int PAW = $clog2(MAX_PHRASE + 1),
   localparam int LW  = $clog2(MAX_PHRASE + 2)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire op_type               op,
   output dp_status_type             flags,
   input  wire logic [WORD_W-1:0]    req_word,
   input  wire logic                 req_eos,
   input  wire logic                 csr_valid,
   input  wire logic [TOTAL_W-1:0]   csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic      [OUT_W-1:0]     rsp_bytes,
   output logic      [CNT_W-1:0]     rsp_count,
   output logic                      rsp_last,
   output logic      [STATUS_W-1:0]  rsp_status
);

   // Control registers.
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [4:0]          bitcnt_ff, bitcnt_in;
   logic [TOTAL_W-1:0]  emitted_ff, emitted_in;
   logic [1:0]          stopped_ff, stopped_in;
   logic [SLOT_W-1:0]   free_ff, free_in;
   logic [SLOT_W-1:0]   sweep_ff, sweep_in;
   logic [SLOT_W-1:0]   scount_ff, scount_in;
   logic [CODE_W-1:0]   last_code_ff, last_code_in;
   logic [LW-1:0]       last_len_ff, last_len_in;
   logic [CODE_W-1:0]   clr_ff, clr_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Working registers of the current request.
   logic [WORD_W-1:0]   word_ff, word_in;
   logic                eos_ff, eos_in;
   logic [STATUS_W-1:0] st_ff, st_in;
   logic [CODE_W-1:0]   code_ff, code_in;
   logic [CODE_W-1:0]   node_ff, node_in;
   logic [LW-1:0]       len_ff, len_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic [CODE_W-1:0]   cur_ff, cur_in;
   logic                must_ff, must_in;
   logic [7:0]          byte_ff, byte_in;
   logic [CODE_W-1:0]   m_ff, m_in;
   logic [SLOT_W-1:0]   guard_ff, guard_in;
   logic [CODE_W-1:0]   nw_ff, nw_in;
   logic [OUT_W-1:0]    pack_ff, pack_in;
   logic [CNT_W-1:0]    pcnt_ff, pcnt_in;
   logic [OUT_W-1:0]    rsp_bytes_ff, rsp_bytes_in;
   logic [CNT_W-1:0]    rsp_cnt_ff, rsp_cnt_in;
   logic                rsp_last_ff, rsp_last_in;
   logic [STATUS_W-1:0] rsp_st_ff, rsp_st_in;

   // Memory ports.
   logic [CODE_W-1:0] naddr;
   logic [7:0]        sym_rd;
   logic [CODE_W-1:0] par_rd, fc_rd, nxt_rd, prv_rd;
   logic              sym_we, par_we, fc_we, nxt_we, prv_we, pb_we;
   logic [CODE_W-1:0] sym_wa, par_wa, fc_wa, nxt_wa, prv_wa;
   logic [7:0]        sym_wd;
   logic [CODE_W-1:0] par_wd, fc_wd, nxt_wd, prv_wd;
   logic [PAW-1:0]    pb_wa, pb_ra;
   logic [7:0]        pb_rd;

   logic              out_free;
   logic              pack_full;
   logic              emit_ok;
   logic [SLOT_W-1:0] sweep_next;

   lzt_ram #(.WIDTH(8), .DEPTH(int'(NODES))) u_symbol (
      .clock(clock), .wr_en(sym_we), .wr_addr(sym_wa), .wr_data(sym_wd),
      .rd_addr(naddr), .rd_data(sym_rd));
   lzt_ram #(.WIDTH(CODE_W), .DEPTH(int'(NODES))) u_parent (
      .clock(clock), .wr_en(par_we), .wr_addr(par_wa), .wr_data(par_wd),
      .rd_addr(naddr), .rd_data(par_rd));
   lzt_ram #(.WIDTH(CODE_W), .DEPTH(int'(NODES))) u_first_child (
      .clock(clock), .wr_en(fc_we), .wr_addr(fc_wa), .wr_data(fc_wd),
      .rd_addr(naddr), .rd_data(fc_rd));
   lzt_ram #(.WIDTH(CODE_W), .DEPTH(int'(NODES))) u_next_sibling (
      .clock(clock), .wr_en(nxt_we), .wr_addr(nxt_wa), .wr_data(nxt_wd),
      .rd_addr(naddr), .rd_data(nxt_rd));
   lzt_ram #(.WIDTH(CODE_W), .DEPTH(int'(NODES))) u_prev_sibling (
      .clock(clock), .wr_en(prv_we), .wr_addr(prv_wa), .wr_data(prv_wd),
      .rd_addr(naddr), .rd_data(prv_rd));
   lzt_ram #(.WIDTH(8), .DEPTH(MAX_PHRASE + 1)) u_phrase (
      .clock(clock), .wr_en(pb_we), .wr_addr(pb_wa), .wr_data(sym_rd),
      .rd_addr(pb_ra), .rd_data(pb_rd));

   // Phrase buffer addressing: the walk fills from the top, reads run from the start.
   assign pb_wa = PAW'(MAX_PHRASE) - PAW'(len_ff);
   assign pb_ra = PAW'(MAX_PHRASE + 1) - PAW'(len_ff) + PAW'(idx_ff);

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign pack_full  = (pcnt_ff == CNT_W'(BYTES_PER_RESULT));
   assign emit_ok    = (emitted_ff < total_ff);
   assign sweep_next = sweep_ff + SLOT_W'(1);

   // Node memory read address for the operation issued this cycle.
   always_comb begin
      case (op)
         OP_LATCH_BYTE, OP_LINK_RD: naddr = cur_ff;
         OP_SRCH_RD:                naddr = m_ff;
         OP_SWP_RD:                 naddr = sweep_ff[CODE_W-1:0];
         OP_UNL_RD:                 naddr = nw_ff;
         default:                   naddr = node_ff;
      endcase
   end

   // Conditions for the controller.
   always_comb begin
      flags.clear_last   = (clr_ff == NIL);
      flags.eos          = eos_ff;
      flags.stopped      = (stopped_ff != 2'd0);
      flags.size_reached = !emit_ok;
      flags.code_ready   = (bitcnt_ff >= 5'(CODE_W));
      flags.node_nil     = (node_ff == NIL);
      flags.len_over     = (int'(len_ff) > MAX_PHRASE);
      flags.emit_more    = (idx_ff < len_ff);
      flags.emit_ok      = emit_ok;
      flags.pack_full    = pack_full;
      flags.out_free     = out_free;
      flags.has_last     = (last_code_ff != NIL);
      flags.ext_more     = (idx_ff < len_ff) && (int'(idx_ff) < MAX_EXTEND)
                           && ((int'(last_len_ff) + int'(idx_ff)) < MAX_PHRASE);
      flags.must_alloc   = must_ff;
      flags.m_nil        = (m_ff == NIL);
      flags.sym_match    = (sym_rd == byte_ff);
      flags.guard_max    = (guard_ff == NODES);
      flags.free_avail   = (free_ff <= LAST_SLOT);
      flags.swp_hit      = (sweep_ff[CODE_W-1:0] != cur_ff) && (fc_rd == NIL);
      flags.swp_exhaust  = (scount_ff >= NODES);
   end

   // Operation decoder: next register values and memory writes.
   always_comb begin
      total_in     = csr_valid ? csr_data : total_ff;
      acc_in       = acc_ff;
      bitcnt_in    = bitcnt_ff;
      emitted_in   = emitted_ff;
      stopped_in   = stopped_ff;
      free_in      = free_ff;
      sweep_in     = sweep_ff;
      scount_in    = scount_ff;
      last_code_in = last_code_ff;
      last_len_in  = last_len_ff;
      clr_in       = clr_ff;
      word_in      = word_ff;
      eos_in       = eos_ff;
      st_in        = st_ff;
      code_in      = code_ff;
      node_in      = node_ff;
      len_in       = len_ff;
      idx_in       = idx_ff;
      cur_in       = cur_ff;
      must_in      = must_ff;
      byte_in      = byte_ff;
      m_in         = m_ff;
      guard_in     = guard_ff;
      nw_in        = nw_ff;
      pack_in      = pack_ff;
      pcnt_in      = pcnt_ff;
      rsp_bytes_in = rsp_bytes_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      sym_we = 1'b0; sym_wa = nw_ff; sym_wd = byte_ff;
      par_we = 1'b0; par_wa = nw_ff; par_wd = cur_ff;
      fc_we  = 1'b0; fc_wa  = nw_ff; fc_wd  = NIL;
      nxt_we = 1'b0; nxt_wa = nw_ff; nxt_wd = fc_rd;
      prv_we = 1'b0; prv_wa = nw_ff; prv_wd = NIL;
      pb_we  = 1'b0;

      unique case (op)
         OP_NONE: begin
         end
         OP_CLEAR: begin
            sym_we = 1'b1; par_we = 1'b1; fc_we = 1'b1; nxt_we = 1'b1; prv_we = 1'b1;
            sym_wa = clr_ff; par_wa = clr_ff; fc_wa = clr_ff;
            nxt_wa = clr_ff; prv_wa = clr_ff;
            sym_wd = (clr_ff < CODE_W'(256)) ? clr_ff[7:0] : 8'hff;
            par_wd = NIL; fc_wd = NIL; nxt_wd = NIL; prv_wd = NIL;
            clr_in = clr_ff + CODE_W'(1);
         end
         OP_ACCEPT: begin
            word_in = req_word;
            eos_in  = req_eos;
            pack_in = '0;
            pcnt_in = '0;
         end
         OP_SETTLE: begin
            // Latched status wins; otherwise size reached latches, else end of input.
            if (stopped_ff != 2'd0) begin
               st_in = {1'b0, stopped_ff};
            end else if (!emit_ok) begin
               stopped_in = 2'(ST_SIZE);
               st_in      = ST_SIZE;
            end else begin
               st_in = eos_ff ? ST_SHORT : ST_OK;
            end
         end
         OP_LOAD: begin
            if (bitcnt_ff < 5'(CODE_W)) begin
               acc_in    = acc_ff + (ACC_W'(word_ff) << (5'd16 - bitcnt_ff));
               bitcnt_in = bitcnt_ff + 5'd16;
            end
         end
         OP_TAKE_CODE: begin
            code_in   = acc_ff[ACC_W-1 -: CODE_W];
            node_in   = acc_ff[ACC_W-1 -: CODE_W];
            acc_in    = acc_ff << CODE_W;
            bitcnt_in = bitcnt_ff - 5'(CODE_W);
            len_in    = '0;
         end
         OP_FAIL_LONG: begin
            stopped_in = 2'(ST_LONG);
         end
         OP_WALK_RD: begin
         end
         OP_WALK_WR: begin
            pb_we   = 1'b1;
            len_in  = len_ff + LW'(1);
            node_in = par_rd;
         end
         OP_EMIT_BEGIN: begin
            idx_in = '0;
         end
         OP_EMIT_BYTE: begin
            // A full word goes out first; the new byte then opens the next word.
            if (emit_ok) begin
               if (pack_full) begin
                  rsp_valid_in = 1'b1;
                  rsp_bytes_in = pack_ff;
                  rsp_cnt_in   = pcnt_ff;
                  rsp_last_in  = 1'b0;
                  rsp_st_in    = ST_OK;
                  pack_in      = OUT_W'(pb_rd);
                  pcnt_in      = CNT_W'(1);
               end else begin
                  pack_in[8*pcnt_ff +: 8] = pb_rd;
                  pcnt_in                 = pcnt_ff + CNT_W'(1);
               end
               emitted_in = emitted_ff + TOTAL_W'(1);
            end
            idx_in = idx_ff + LW'(1);
         end
         OP_CODE_DONE: begin
            last_code_in = code_ff;
            last_len_in  = len_ff;
         end
         OP_EXT_BEGIN: begin
            cur_in  = last_code_ff;
            idx_in  = '0;
            must_in = 1'b0;
         end
         OP_LATCH_BYTE: begin
            byte_in = pb_rd;
         end
         OP_HEAD: begin
            m_in     = fc_rd;
            guard_in = '0;
         end
         OP_NO_MATCH: begin
            must_in = 1'b1;
         end
         OP_SRCH_RD: begin
         end
         OP_MATCH: begin
            cur_in = m_ff;
            idx_in = idx_ff + LW'(1);
         end
         OP_SRCH_NEXT: begin
            m_in     = nxt_rd;
            guard_in = guard_ff + SLOT_W'(1);
         end
         OP_ALLOC_FREE: begin
            nw_in   = free_ff[CODE_W-1:0];
            free_in = free_ff + SLOT_W'(1);
         end
         OP_SWEEP_BEGIN: begin
            sweep_in  = (sweep_ff > LAST_SLOT) ? FIRST_SLOT : sweep_ff;
            scount_in = '0;
         end
         OP_SWP_RD: begin
         end
         OP_SWP_TAKE: begin
            nw_in    = sweep_ff[CODE_W-1:0];
            sweep_in = sweep_next;
         end
         OP_SWP_NEXT: begin
            sweep_in  = (sweep_next > LAST_SLOT) ? FIRST_SLOT : sweep_next;
            scount_in = scount_ff + SLOT_W'(1);
         end
         OP_FAIL_NODE: begin
            stopped_in = 2'(ST_NONODE);
         end
         OP_UNL_RD: begin
         end
         OP_UNLINK: begin
            // Take the reused node out of its sibling list.
            if (prv_rd == NIL) begin
               fc_we = (par_rd != NIL);
               fc_wa = par_rd;
               fc_wd = nxt_rd;
            end else begin
               nxt_we = 1'b1;
               nxt_wa = prv_rd;
               nxt_wd = nxt_rd;
            end
            prv_we = (nxt_rd != NIL);
            prv_wa = nxt_rd;
            prv_wd = prv_rd;
         end
         OP_LINK_NEW: begin
            sym_we = 1'b1;
            par_we = 1'b1;
            fc_we  = 1'b1;
            prv_we = 1'b1;
         end
         OP_LINK_RD: begin
         end
         OP_LINK_HEAD: begin
            // Push the new node at the head of the child list of the current node.
            nxt_we = 1'b1;
            nxt_wa = nw_ff;
            nxt_wd = fc_rd;
            prv_we = (fc_rd != NIL);
            prv_wa = fc_rd;
            prv_wd = nw_ff;
            fc_we  = 1'b1;
            fc_wa  = cur_ff;
            fc_wd  = nw_ff;
            cur_in = nw_ff;
            idx_in = idx_ff + LW'(1);
         end
         OP_FINISH: begin
            rsp_valid_in = 1'b1;
            rsp_bytes_in = pack_ff;
            rsp_cnt_in   = pcnt_ff;
            rsp_last_in  = 1'b1;
            rsp_st_in    = st_ff;
         end
         default: begin
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         acc_ff       <= '0;
         bitcnt_ff    <= '0;
         emitted_ff   <= '0;
         stopped_ff   <= '0;
         free_ff      <= FIRST_SLOT;
         sweep_ff     <= FIRST_SLOT;
         scount_ff    <= '0;
         last_code_ff <= NIL;
         last_len_ff  <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         pcnt_ff      <= '0;
      end else begin
         total_ff     <= total_in;
         acc_ff       <= acc_in;
         bitcnt_ff    <= bitcnt_in;
         emitted_ff   <= emitted_in;
         stopped_ff   <= stopped_in;
         free_ff      <= free_in;
         sweep_ff     <= sweep_in;
         scount_ff    <= scount_in;
         last_code_ff <= last_code_in;
         last_len_ff  <= last_len_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         pcnt_ff      <= pcnt_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      word_ff      <= word_in;
      eos_ff       <= eos_in;
      st_ff        <= st_in;
      code_ff      <= code_in;
      node_ff      <= node_in;
      len_ff       <= len_in;
      idx_ff       <= idx_in;
      cur_ff       <= cur_in;
      must_ff      <= must_in;
      byte_ff      <= byte_in;
      m_ff         <= m_in;
      guard_ff     <= guard_in;
      nw_ff        <= nw_in;
      pack_ff      <= pack_in;
      rsp_bytes_ff <= rsp_bytes_in;
      rsp_cnt_ff   <= rsp_cnt_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_st_ff    <= rsp_st_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_bytes  = rsp_bytes_ff;
   assign rsp_count  = rsp_cnt_ff;
   assign rsp_last   = rsp_last_ff;
   assign rsp_status = rsp_st_ff;

   // The free counter stops one past the last slot.
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= SLOT_W'(NIL))
      else $error("free slot counter ran past the table");

   // The accumulator never holds more than one word beyond a partial code.
   a_bit_bound: assert property (@(posedge clock) disable iff (reset)
      bitcnt_ff < 5'd29)
      else $error("bit accumulator overfilled");

   // A result is only pushed into a free output register.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      (op == OP_FINISH || (op == OP_EMIT_BYTE && emit_ok && pack_full)) |-> out_free)
      else $error("result pushed over a waiting result");

   // The packer never holds more bytes than one result carries.
   a_pack_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= CNT_W'(BYTES_PER_RESULT))
      else $error("result packer overfilled");

endmodule

`default_nettype wire

### design/lz_trie_phrase_decoder.sv
// Top level of the 13-bit trie phrase decoder.
// Each request carries one 16-bit packed word (or an end-of-stream flag) and produces one or
// more results of up to four bytes, the last one flagged and carrying the status. Requests are
// handled one at a time. After reset the block clears the trie memories before it accepts its
// first request. For each of the at most two codes that a request completes, the block walks
// the parent chain once per phrase byte, outputs the phrase bytes, and for each of up to four
// extension bytes searches the siblings in the child list; when the table is full, a reuse
// sweep probes nodes for one without children, and the code fails when none can be reused.
// Output stalls only hold the block when a result is pushed.
`default_nettype none

module lz_trie_phrase_decoder import lzt_pkg::*; #(
   parameter int MAX_PHRASE = 100
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [15:0]         req_tdata,   // [15:0] packed_word
   input  wire logic                req_tuser,   // [0] end_of_stream
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic      [39:0]         rsp_tdata,   // [31:0] out_bytes, [34:32] byte_count
   output logic                     rsp_tlast,   // last_of_run
   output logic      [2:0]          rsp_tuser,   // [2:0] status
   input  wire logic                csr_valid,
   output logic                     csr_ready,
   input  wire logic [TOTAL_W-1:0]  csr_data    // [30:0] total_size
);

   dp_status_type   flags;
   op_type          op;
   logic [OUT_W-1:0] rsp_bytes;
   logic [CNT_W-1:0] rsp_count;

   // The size register may be written at any time the block is idle.
   assign csr_ready = 1'b1;

   lzt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .op         (op)
   );

   lzt_dpath #(.MAX_PHRASE(MAX_PHRASE)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .op         (op),
      .flags      (flags),
      .req_word   (req_tdata),
      .req_eos    (req_tuser),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_bytes  (rsp_bytes),
      .rsp_count  (rsp_count),
      .rsp_last   (rsp_tlast),
      .rsp_status (rsp_tuser)
   );

   // Pack the result fields, lowest field first, padded to whole bytes.
   assign rsp_tdata = {5'b0, rsp_count, rsp_bytes};

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// Self-checking testbench of the trie phrase decoder, with its own model of the trie.
`default_nettype none

module testbench;
   import lzt_pkg::*;

   localparam int MAX_PH      = 100;
   localparam int STEP_MAX    = 2 * (MAX_PH + 1);
   localparam int IDLE_LIMIT  = 60000;
   localparam int DRAIN_WAIT  = 60;
   localparam int RANDOM_A    = 200;
   localparam int RANDOM_B    = 200;
   localparam int HOLD_CYCLES = 400;

   typedef struct packed {
      logic [31:0] bytes;
      logic [2:0]  count;
      logic        last;
      logic [2:0]  status;
   } rsp_item_type;

   typedef struct packed {
      logic        eos;
      logic [15:0] word;
      logic        typed;
      logic [31:0] bytes;
      logic [2:0]  count;
      logic [2:0]  status;
   } stim_row_type;

   // Clock and block ports.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;
   logic                req_tuser = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [39:0]         rsp_tdata;
   logic                rsp_tlast;
   logic [2:0]          rsp_tuser;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [TOTAL_W-1:0]  csr_data = '0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lz_trie_phrase_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Shadow copy of the trie and of the decoder state.
   logic [7:0]         sym_mem    [0:8191];
   logic [12:0]        parent_mem [0:8191];
   logic [12:0]        child_mem  [0:8191];
   logic [12:0]        next_mem   [0:8191];
   logic [12:0]        prev_mem   [0:8191];
   logic [7:0]         phrase     [0:MAX_PH];
   int unsigned        free_slot, sweep_cursor, last_code, last_len;
   logic [31:0]        acc;
   int unsigned        acc_bits;
   int unsigned        emitted;
   int unsigned        total_size;
   logic [2:0]         stopped;
   logic [7:0]         step_bytes[$];

   rsp_item_type       pending_rsp[$];
   int                 fail_count = 0;

   // Directed expectation travelling alongside the request currently offered.
   logic               row_typed = 1'b0;
   rsp_item_type       row_expect = '0;

   // Control between the sender and the receiver.
   bit                 rsp_quiet = 1'b0;
   bit                 hold_req = 1'b0;
   bit                 send_quiet = 1'b0;

   // Bit packer of the random part: codes go in 13 bits at a time, words come out MSB first.
   logic [63:0]        pack_bits;
   int                 pack_n;

   initial begin
      for (int i = 0; i < 8192; i++) begin
         sym_mem[i]    = (i < 256) ? 8'(i) : 8'hff;
         parent_mem[i] = NIL;
         child_mem[i]  = NIL;
         next_mem[i]   = NIL;
         prev_mem[i]   = NIL;
      end
      free_slot    = FIRST_SLOT;
      sweep_cursor = FIRST_SLOT;
      last_code    = NIL;
      last_len     = 0;
      acc          = '0;
      acc_bits     = 0;
      emitted      = 0;
      total_size   = 0;
      stopped      = ST_OK;
   end

   // Hands out a node: from the free counter, or by sweeping for a childless one.
   task automatic take_node(input int unsigned cur, output int unsigned got,
                            output logic [2:0] err);
      int unsigned sweep, n, after, prv;
      sweep = 0;
      err   = ST_OK;
      got   = 0;
      if (free_slot <= LAST_SLOT) begin
         got = free_slot;
         free_slot++;
         return;
      end
      forever begin
         if (sweep_cursor > LAST_SLOT) sweep_cursor = FIRST_SLOT;
         if (sweep_cursor != cur && child_mem[sweep_cursor] == NIL) break;
         sweep_cursor++;
         sweep++;
         if (sweep > NODES) begin
            err = ST_NONODE;
            return;
         end
      end
      n = sweep_cursor;
      sweep_cursor = n + 1;
      after = next_mem[n];
      prv   = prev_mem[n];
      if (prv == NIL) begin
         if (parent_mem[n] != NIL) child_mem[parent_mem[n]] = 13'(after);
      end else begin
         next_mem[prv] = 13'(after);
      end
      if (after != NIL) prev_mem[after] = 13'(prv);
      got = n;
   endtask

   // Walks one code to its phrase, emits it and extends the previous phrase.
   task automatic decode_code(input logic [12:0] code, output logic [2:0] err);
      int unsigned node, len, start, cur, m, guard, nw, head;
      logic [7:0]  b;
      logic [2:0]  e;
      bit          must_alloc;
      err = ST_OK;
      node = code;
      len = 0;
      must_alloc = 1'b0;
      while (node != NIL) begin
         if (len > MAX_PH) begin
            err = ST_LONG;
            return;
         end
         phrase[MAX_PH - len] = sym_mem[node];
         len++;
         node = parent_mem[node];
      end
      start = MAX_PH + 1 - len;
      for (int unsigned i = 0; i < len; i++) begin
         if (emitted < total_size && step_bytes.size() < STEP_MAX) begin
            step_bytes.push_back(phrase[start + i]);
            emitted++;
         end
      end
      if (last_code != NIL) begin
         cur = last_code;
         for (int unsigned i = 0; i < len && i < MAX_EXTEND && last_len + i < MAX_PH; i++) begin
            b = phrase[start + i];
            if (!must_alloc) begin
               m = child_mem[cur];
               guard = 0;
               while (m != NIL && sym_mem[m] != b && guard < NODES) begin
                  m = next_mem[m];
                  guard++;
               end
               if (m != NIL && sym_mem[m] == b) begin
                  cur = m;
                  continue;
               end
               must_alloc = 1'b1;
            end
            take_node(cur, nw, e);
            if (e != ST_OK) begin
               err = e;
               return;
            end
            sym_mem[nw]    = b;
            parent_mem[nw] = 13'(cur);
            child_mem[nw]  = NIL;
            prev_mem[nw]   = NIL;
            head = child_mem[cur];
            next_mem[nw]   = 13'(head);
            if (head != NIL) prev_mem[head] = 13'(nw);
            child_mem[cur] = 13'(nw);
            cur = nw;
         end
      end
      last_code = code;
      last_len  = len;
   endtask

   // Works out the results of one request and queues them.
   task automatic predict_request(input logic eos, input logic [15:0] word,
                                  output rsp_item_type first);
      logic [2:0]   st, err;
      logic [12:0]  code;
      int unsigned  nres;
      rsp_item_type item;
      step_bytes.delete();
      if (eos) begin
         if (stopped != ST_OK) st = stopped;
         else if (emitted >= total_size) begin
            stopped = ST_SIZE;
            st = ST_SIZE;
         end else st = ST_SHORT;
      end else if (stopped != ST_OK) begin
         st = stopped;
      end else if (emitted >= total_size) begin
         stopped = ST_SIZE;
         st = ST_SIZE;
      end else begin
         if (acc_bits < 13) begin
            acc = acc + (32'(word) << (16 - acc_bits));
            acc_bits += 16;
         end
         while (acc_bits >= 13 && stopped == ST_OK) begin
            if (emitted >= total_size) begin
               stopped = ST_SIZE;
               break;
            end
            code = acc[31:19];
            acc = acc << 13;
            acc_bits -= 13;
            decode_code(code, err);
            if (err != ST_OK) stopped = err;
         end
         if (stopped == ST_OK && emitted >= total_size) stopped = ST_SIZE;
         st = stopped;
      end
      nres = (step_bytes.size() + BYTES_PER_RESULT - 1) / BYTES_PER_RESULT;
      if (nres == 0) nres = 1;
      for (int unsigned k = 0; k < nres; k++) begin
         item = '0;
         for (int unsigned j = 0; j < BYTES_PER_RESULT; j++) begin
            if (k * BYTES_PER_RESULT + j < step_bytes.size()) begin
               item.bytes[8*j +: 8] = step_bytes[k * BYTES_PER_RESULT + j];
               item.count++;
            end
         end
         item.last   = (k + 1 == nres);
         item.status = item.last ? st : ST_OK;
         if (k == 0) first = item;
         pending_rsp.push_back(item);
      end
   endtask

   // Monitor: configuration, predictions, result checks and the watchdog.
   int idle_cycles = 0;
   always @(posedge clock) begin
      rsp_item_type got, want, first;
      bit           seen;
      if (!reset) begin
         seen = (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready)
                || (req_tvalid && req_tready);
         idle_cycles <= seen ? 0 : idle_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            got.bytes  = rsp_tdata[31:0];
            got.count  = rsp_tdata[34:32];
            got.last   = rsp_tlast;
            got.status = rsp_tuser;
            if (pending_rsp.size() == 0) begin
               $error("result with nothing expected: bytes %h count %0d", got.bytes, got.count);
               fail_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (got.bytes !== want.bytes) begin
                  $error("out_bytes: expected %h, actual %h", want.bytes, got.bytes);
                  fail_count++;
               end
               if (got.count !== want.count) begin
                  $error("byte_count: expected %0d, actual %0d", want.count, got.count);
                  fail_count++;
               end
               if (got.last !== want.last) begin
                  $error("last_of_run: expected %0d, actual %0d", want.last, got.last);
                  fail_count++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            total_size = csr_data;
         end
         if (req_tvalid && req_tready) begin
            predict_request(req_tuser, req_tdata, first);
            if (row_typed && first !== row_expect) begin
               $error("directed row: expected %h, predicted %h", row_expect, first);
               fail_count++;
            end
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Receiver: random readiness, one long hold-off on request, none at the end.
   initial begin
      forever begin
         if (rsp_quiet) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
         end else begin
            rsp_tready <= 1'($urandom_range(0, 1));
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
      end
   end

   // Offers one request and waits for it to be taken; valid stays high between requests unless a random gap is drawn.
   task automatic send_request(input logic eos, input logic [15:0] word,
                               input logic typed, input rsp_item_type exp);
      if (!send_quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= eos;
      req_tdata  <= eos ? 16'($urandom) : word;
      row_typed  <= typed;
      row_expect <= exp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Lets the block run dry, then writes the size register.
   task automatic write_size(input logic [TOTAL_W-1:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Picks a code that mostly names a recent node, so phrases grow and get reused.
   function automatic logic [12:0] pick_code();
      int unsigned r, lo;
      r = $urandom_range(0, 99);
      if (r < 65 && free_slot > FIRST_SLOT) begin
         lo = (free_slot > FIRST_SLOT + 40) ? free_slot - 40 : FIRST_SLOT;
         return 13'($urandom_range(lo, free_slot - 1));
      end
      if (r < 85) return 13'($urandom_range(0, 255));
      if (r < 90) return NIL;
      return 13'($urandom);
   endfunction

   task automatic send_random(input int count, input int hold_at, input int pause_at);
      logic [15:0] word;
      for (int n = 0; n < count; n++) begin
         if (n == hold_at) hold_req = 1'b1;
         if (n == pause_at) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
            wait (pending_rsp.size() == 0);
            @(posedge clock);
         end
         if ($urandom_range(0, 49) == 0) begin
            send_request(1'b1, 16'h0, 1'b0, '0);
         end else begin
            while (pack_n < 16) begin
               pack_bits = (pack_bits << 13) | 64'(pick_code());
               pack_n += 13;
            end
            word = 16'(pack_bits >> (pack_n - 16));
            pack_n -= 16;
            send_request(1'b0, word, 1'b0, '0);
         end
      end
   endtask

   // Directed rows: reset behaviour, extreme words, empty and unused codes.
   stim_row_type dir_rows [14] = '{
      '{1'b1, 16'h0000, 1'b1, 32'h0, 3'd0, ST_SHORT},
      '{1'b0, 16'h0000, 1'b1, 32'h0, 3'd1, ST_OK},
      '{1'b0, 16'hffff, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'hfff8, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h1234, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'haaaa, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h5555, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b1, 16'h0000, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h8001, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h7fff, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h0100, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'hfedc, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'h00ff, 1'b0, 32'h0, 3'd0, ST_OK},
      '{1'b0, 16'hffff, 1'b0, 32'h0, 3'd0, ST_OK}
   };

   // Main sequence.
   initial begin
      rsp_item_type exp;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Largest size first, so that the stream runs freely.
      write_size(31'h7fffffff);
      foreach (dir_rows[i]) begin
         exp.bytes  = dir_rows[i].bytes;
         exp.count  = dir_rows[i].count;
         exp.last   = 1'b1;
         exp.status = dir_rows[i].status;
         send_request(dir_rows[i].eos, dir_rows[i].word, dir_rows[i].typed, exp);
      end

      // Align the packer to the codes still held in the accumulator.
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (pending_rsp.size() == 0);
      pack_bits = '0;
      pack_n = (acc_bits == 0) ? 0 : 13 - acc_bits;
      send_random(RANDOM_A, -1, -1);

      // A different size, with a long output hold-off and a full pause.
      write_size(31'h40000000 | 31'($urandom_range(0, 1000)));
      pack_n = (acc_bits == 0) ? 0 : 13 - acc_bits;
      send_random(RANDOM_B, 20, 120);

      // Last part without idling: reach the size, then the smallest size.
      rsp_quiet  = 1'b1;
      send_quiet = 1'b1;
      write_size(31'(emitted + 57));
      pack_n = (acc_bits == 0) ? 0 : 13 - acc_bits;
      send_random(30, -1, -1);
      write_size(31'h0);
      send_random(4, -1, -1);
      send_request(1'b1, 16'h0, 1'b0, '0);
      req_tvalid <= 1'b0;

      @(posedge clock);
      wait (pending_rsp.size() == 0);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
